// ===== rtl/dlfbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfbc_pkg
// Widths, permutation tables and bit-selection functions for the Feistel
// block cipher with the DES structure and a fixed selection in place of S-boxes.
// ----------------------------------------------------------------------------
package dlfbc_pkg;

    localparam int BLOCK_W  = 64;
    localparam int HALF_W   = 32;
    localparam int SUBKEY_W = 48;
    localparam int CD_W     = 28;
    localparam int ROUNDS   = 16;

    // Tables are 1-based, first bit is the most significant one.
    localparam logic [7:0] IP_TAB [64] = '{
        8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
        8'd60, 8'd52, 8'd44, 8'd36, 8'd28, 8'd20, 8'd12, 8'd4,
        8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
        8'd64, 8'd56, 8'd48, 8'd40, 8'd32, 8'd24, 8'd16, 8'd8,
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
        8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
        8'd61, 8'd53, 8'd45, 8'd37, 8'd29, 8'd21, 8'd13, 8'd5,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7
    };

    localparam logic [7:0] FP_TAB [64] = '{
        8'd40, 8'd8, 8'd48, 8'd16, 8'd56, 8'd24, 8'd64, 8'd32,
        8'd39, 8'd7, 8'd47, 8'd15, 8'd55, 8'd23, 8'd63, 8'd31,
        8'd38, 8'd6, 8'd46, 8'd14, 8'd54, 8'd22, 8'd62, 8'd30,
        8'd37, 8'd5, 8'd45, 8'd13, 8'd53, 8'd21, 8'd61, 8'd29,
        8'd36, 8'd4, 8'd44, 8'd12, 8'd52, 8'd20, 8'd60, 8'd28,
        8'd35, 8'd3, 8'd43, 8'd11, 8'd51, 8'd19, 8'd59, 8'd27,
        8'd34, 8'd2, 8'd42, 8'd10, 8'd50, 8'd18, 8'd58, 8'd26,
        8'd33, 8'd1, 8'd41, 8'd9,  8'd49, 8'd17, 8'd57, 8'd25
    };

    localparam logic [7:0] PC1_TAB [56] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
        8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
        8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
        8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
        8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
        8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
        8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam logic [7:0] PC2_TAB [48] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28,
        8'd15, 8'd6,  8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,
        8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40,
        8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
        8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    localparam logic [7:0] EXP_TAB [48] = '{
        8'd32, 8'd1,  8'd2,  8'd3,  8'd4,  8'd5,
        8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
        8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13,
        8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
        8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21,
        8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
        8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29,
        8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd1
    };

    localparam logic [7:0] SEL_TAB [32] = '{
        8'd35, 8'd38, 8'd46, 8'd6,  8'd43, 8'd40, 8'd14, 8'd45,
        8'd33, 8'd19, 8'd26, 8'd15, 8'd23, 8'd8,  8'd22, 8'd10,
        8'd12, 8'd11, 8'd5,  8'd25, 8'd27, 8'd21, 8'd16, 8'd31,
        8'd28, 8'd32, 8'd34, 8'd24, 8'd9,  8'd37, 8'd2,  8'd1
    };

    localparam logic [7:0] PBOX_TAB [32] = '{
        8'd16, 8'd7,  8'd20, 8'd21, 8'd29, 8'd12, 8'd28, 8'd17,
        8'd1,  8'd15, 8'd23, 8'd26, 8'd5,  8'd18, 8'd31, 8'd10,
        8'd2,  8'd8,  8'd24, 8'd14, 8'd32, 8'd27, 8'd3,  8'd9,
        8'd19, 8'd13, 8'd30, 8'd6,  8'd22, 8'd11, 8'd4,  8'd25
    };

    // Total left rotation of C and D reached after each round.
    localparam logic [4:0] CUM_ROT [ROUNDS] = '{
        5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
        5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
    };

    function automatic logic [63:0] ip_perm(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] pc1_perm(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] pc2_perm(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] expand(input logic [31:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[32-int'(EXP_TAB[i])];
        return r;
    endfunction

    function automatic logic [31:0] select32(input logic [47:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) r[31-i] = v[48-int'(SEL_TAB[i])];
        return r;
    endfunction

    function automatic logic [31:0] pbox(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) r[31-i] = v[32-int'(PBOX_TAB[i])];
        return r;
    endfunction

    // Rotate a 28-bit half left by a constant amount of 1 to 28.
    function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [4:0] s);
        logic [55:0] dbl;
        dbl = {x, x} >> (6'd28 - {1'b0, s});
        return dbl[27:0];
    endfunction

    // Round key after a total rotation of s bits.
    function automatic logic [47:0] round_key(input logic [63:0] key,
                                              input logic [4:0]  s);
        logic [55:0] k56;
        logic [27:0] c;
        logic [27:0] d;
        k56 = pc1_perm(key);
        c   = rotl28(k56[55:28], s);
        d   = rotl28(k56[27:0], s);
        return pc2_perm({c, d});
    endfunction

    function automatic logic [31:0] round_f(input logic [31:0] r,
                                            input logic [47:0] k);
        return pbox(select32(expand(r) ^ k));
    endfunction

endpackage

// ===== rtl/des_like_feistel_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_like_feistel_block_cipher
// Sixteen-stage pipelined Feistel cipher with the DES structure, in which the
// S-box stage is a fixed 48-to-32 bit selection.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                              Direction  Moves
//  input     in_valid, in_ready, action, block_in in         one item per block
//  output    out_valid, out_ready, block_out      out        one item per block
//  key       key_we, key_wdata                    in         64-bit cipher key
//
// out_valid rises once an accepted item has passed all 16 Feistel rounds, since
// each round has its own register stage and the rounds set the latency.
// One item enters per cycle while the output side takes items. Reset clears
// every stage valid bit and the key. A stall at the output holds the last stage
// and ready runs back stage by stage, so bubbles still fill while the output is
// held. The key must only be written while the pipeline is empty.
module des_like_feistel_block_cipher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_we,
    input  logic [dlfbc_pkg::BLOCK_W-1:0] key_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [dlfbc_pkg::BLOCK_W-1:0] block_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dlfbc_pkg::BLOCK_W-1:0] block_out
);
    import dlfbc_pkg::*;

    // Payload carried by each pipeline stage.
    typedef struct packed {
        logic              decrypt;
        logic [HALF_W-1:0] left;
        logic [HALF_W-1:0] right;
    } stage_t;

    logic [BLOCK_W-1:0]  cipher_key_reg;
    logic [SUBKEY_W-1:0] rkey [ROUNDS];

    // Stage k holds an item after round k has been applied.
    logic [ROUNDS-1:0]   valid_reg;
    stage_t              stage_reg  [ROUNDS];
    stage_t              stage_next [ROUNDS];
    stage_t              stage_in   [ROUNDS];
    logic [ROUNDS-1:0]   valid_in;
    logic [ROUNDS:0]     stage_rdy;

    logic [BLOCK_W-1:0]  ip_block;

    // The key register is the only configuration state. Round keys are pure
    // wiring off it: PC-1, a fixed rotation per round, then PC-2.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
        end
        else if (key_we)
        begin
            cipher_key_reg <= key_wdata;
        end
    end

    for (genvar k = 0; k < ROUNDS; k++)
    begin : g_rkey
        assign rkey[k] = round_key(cipher_key_reg, CUM_ROT[k]);
    end

    // The initial permutation is wiring and folds into the first stage.
    assign ip_block = ip_perm(block_in);

    // A stage can take a new item when it is empty or its item moves on.
    assign stage_rdy[ROUNDS] = out_ready;
    assign in_ready          = stage_rdy[0];

    for (genvar k = 0; k < ROUNDS; k++)
    begin : g_stage
        logic [SUBKEY_W-1:0] key_sel;
        logic [HALF_W-1:0]   new_left;

        assign stage_rdy[k] = ~valid_reg[k] | stage_rdy[k+1];

        if (k == 0)
        begin : g_first
            assign valid_in[k]          = in_valid;
            assign stage_in[k].decrypt = action;
            assign stage_in[k].left    = ip_block[BLOCK_W-1:HALF_W];
            assign stage_in[k].right   = ip_block[HALF_W-1:0];
        end
        else
        begin : g_next
            assign valid_in[k] = valid_reg[k-1];
            assign stage_in[k] = stage_reg[k-1];
        end

        // Decryption runs the same schedule backwards.
        assign key_sel  = stage_in[k].decrypt ? rkey[ROUNDS-1-k] : rkey[k];
        assign new_left = stage_in[k].left ^ round_f(stage_in[k].right, key_sel);

        always_comb
        begin
            stage_next[k].decrypt = stage_in[k].decrypt;
            if (k == ROUNDS - 1)
            begin
                // No swap after the last round.
                stage_next[k].left  = new_left;
                stage_next[k].right = stage_in[k].right;
            end
            else
            begin
                stage_next[k].left  = stage_in[k].right;
                stage_next[k].right = new_left;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stage_rdy[k])
            begin
                valid_reg[k] <= valid_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_rdy[k] && valid_in[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    // The final permutation is wiring off the last stage register.
    assign out_valid = valid_reg[ROUNDS-1];
    assign block_out = fp_perm({stage_reg[ROUNDS-1].left, stage_reg[ROUNDS-1].right});

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An accepted item always lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    // The input side only stalls when the first stage is full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg[0])
        else $error("input stalled with an empty first stage");

    // Back pressure is the only source of an input stall.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> !out_ready)
        else $error("input stalled while output is taking items");

    // With no item entering or leaving, the item count in flight holds.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) && !(out_valid && out_ready)
        |=> $countones(valid_reg) == $past($countones(valid_reg)))
        else $error("item lost or duplicated inside the pipeline");

endmodule
